// ===== hdl/hci_pkg.sv =====
package hci_pkg;

  localparam int COORD_W     = 16;
  localparam int ORD_W       = 5;
  localparam int IDX_W       = 32;
  localparam int LVL_PER_STG = 4;
  localparam int COORD_IW    = $clog2(COORD_W);
  localparam int IDX_IW      = $clog2(IDX_W);

  localparam logic [ORD_W-1:0] ORDER_RST = 5'd16;

  // Rotation advance, indexed by the rotated quadrant digit.
  localparam logic [1:0] ROT_STEP [4] = '{2'd3, 2'd0, 2'd0, 2'd1};

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               over_x;
    logic               over_y;
    logic [ORD_W-1:0]   order;
    logic [1:0]         rot;
    logic [1:0]         inv;
    logic [IDX_W-1:0]   idx;
  } pipe_t;

  // Walks LVL_PER_STG bit levels, starting at level top_b and going down.
  // Levels below zero or at or above the order leave the word untouched.
  function automatic pipe_t walk_levels(pipe_t p, int top_b);
    pipe_t               q;
    int                  b;
    logic                xhi;
    logic                yhi;
    logic [1:0]          quad;
    logic [1:0]          seg;
    logic [COORD_IW-1:0] bit_i;
    logic [IDX_IW-1:0]   dig_i;
    q = p;
    for (int j = 0; j < LVL_PER_STG; j++) begin
      b = top_b - j;
      if (b >= 0 && b < int'(q.order)) begin
        bit_i = b[COORD_IW-1:0];
        dig_i = IDX_IW'(2 * b);
        xhi  = q.over_x | ((b < COORD_W) && q.x[bit_i]);
        yhi  = q.over_y | ((b < COORD_W) && q.y[bit_i]);
        quad = xhi ? (yhi ? 2'd2 : 2'd1) : (yhi ? 2'd3 : 2'd0);
        seg  = quad + q.rot;
        if (b < IDX_W / 2) begin
          q.idx[dig_i +: 2] = seg ^ q.inv;
        end
        if (seg == 2'd0 || seg == 2'd3) begin
          q.inv = q.inv ^ 2'd3;
        end
        q.rot = q.rot + ROT_STEP[seg];
      end
    end
    return q;
  endfunction

endpackage

// ===== hdl/hilbert_curve_index_top.sv =====
// Hilbert curve index, two dimensions. Each input word carries a point
// (in_x_coord, in_y_coord) and yields one output word with the point's
// distance along a Hilbert curve of side two to the power of the order.
// The user must write the order through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block does not enforce this. It resets to 16 and
// values above MAX_ORDER act as MAX_ORDER. Order zero gives index 0. A
// coordinate bit at or above the order counts as the upper half at every
// level, and only the low 32 bits of the index are kept. The block accepts
// one point per cycle unless the output stalls it. One entry stage clamps
// the order and flags coordinate bits above it, then one stage walks every
// four bit levels of the curve, since the rotation and inversion state runs
// through the levels in order. Each stage holds its word when the next one
// is full and stalled, so a bubble anywhere is taken up and nothing is lost.
module hilbert_curve_index_top #(
  parameter int MAX_ORDER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_x_coord,
  input  logic [15:0] in_y_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_curve_index
);

  localparam int NSTG = (MAX_ORDER + hci_pkg::LVL_PER_STG - 1) / hci_pkg::LVL_PER_STG;
  localparam logic [hci_pkg::ORD_W-1:0] MAX_ORD = hci_pkg::ORD_W'(MAX_ORDER);

  logic [hci_pkg::ORD_W-1:0] order_r;
  logic [hci_pkg::ORD_W-1:0] order_clamp;

  // Stage 0 is the entry stage; stages 1..NSTG each walk four levels.
  logic           vld_r   [NSTG+1];
  hci_pkg::pipe_t stg_r   [NSTG+1];
  hci_pkg::pipe_t stg_nxt [NSTG+1];
  logic           rdy     [NSTG+2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= hci_pkg::ORDER_RST;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  assign order_clamp = (order_r > MAX_ORD) ? MAX_ORD : order_r;

  // A stage can take a new word when it is empty or its word moves on.
  always_comb begin
    rdy[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // Entry stage: the order is fixed here for the rest of the walk, and any
  // coordinate bit above the top level is folded into a sticky flag. The
  // later stages each walk their four levels.
  always_comb begin
    stg_nxt[0].x      = in_x_coord;
    stg_nxt[0].y      = in_y_coord;
    stg_nxt[0].over_x = |(in_x_coord >> order_clamp);
    stg_nxt[0].over_y = |(in_y_coord >> order_clamp);
    stg_nxt[0].order  = order_clamp;
    stg_nxt[0].rot    = 2'd0;
    stg_nxt[0].inv    = 2'd0;
    stg_nxt[0].idx    = '0;
    for (int k = 1; k <= NSTG; k++) begin
      stg_nxt[k] = hci_pkg::walk_levels(stg_r[k-1],
                     MAX_ORDER - 1 - (k - 1) * hci_pkg::LVL_PER_STG);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NSTG; k++) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign in_ready        = rdy[0];
  assign out_valid       = vld_r[NSTG];
  assign out_curve_index = stg_r[NSTG].idx;

endmodule

// ===== hdl/hci_chk.sv =====
module hci_chk #(
  parameter int MAX_ORDER = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [4:0]  cfg_wr_data,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_curve_index
);

  localparam logic [4:0] MAX_ORD = 5'(MAX_ORDER);

  logic [4:0] ord_r;
  logic [4:0] ord_nxt;
  logic [4:0] ord_eff;

  always_comb begin
    ord_nxt = ord_r;
    if (cfg_wr_en) begin
      ord_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= hci_pkg::ORDER_RST;
    end else begin
      ord_r <= ord_nxt;
    end
  end

  assign ord_eff = (ord_r > MAX_ORD) ? MAX_ORD : ord_r;

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_curve_index))
    else $error("stalled output word changed");

  // When the output side takes words the pipeline never pushes back.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although output is ready");

  // An index has only 2*order significant bits.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ord_eff >= 5'd16) ||
                  ((out_curve_index >> {ord_eff, 1'b0}) == 32'd0))
    else $error("curve index beyond the curve length");

endmodule

bind hilbert_curve_index_top hci_chk #(.MAX_ORDER(MAX_ORDER)) u_hci_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_wr_en       (cfg_wr_en),
  .cfg_wr_data     (cfg_wr_data),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_curve_index (out_curve_index)
);

// ===== tb/hilbert_curve_index_checker.sv =====
// Watches both channels and the order register of the Hilbert index block,
// predicts the index of every accepted point and compares it with the output
// words in order.
module hilbert_curve_index_checker #(
  parameter int MAX_ORDER = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [hci_pkg::ORD_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [hci_pkg::COORD_W-1:0] in_x_coord,
  input  logic [hci_pkg::COORD_W-1:0] in_y_coord,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [hci_pkg::IDX_W-1:0]   out_curve_index,
  output int                          fail_count,
  output int                          words_waiting
);

  logic [hci_pkg::ORD_W-1:0] order_shadow;
  logic [hci_pkg::IDX_W-1:0] expected_index_q [$];

  // Distance along the curve, walking the levels from the top one down.
  // Only the current half bit is cleared, so stray upper bits stay set and
  // keep forcing the upper half at the lower levels.
  function automatic logic [hci_pkg::IDX_W-1:0] hilbert_distance(
    input logic [hci_pkg::COORD_W-1:0] x,
    input logic [hci_pkg::COORD_W-1:0] y,
    input logic [hci_pkg::ORD_W-1:0]   ord
  );
    logic [hci_pkg::IDX_W-1:0] px;
    logic [hci_pkg::IDX_W-1:0] py;
    logic [hci_pkg::IDX_W-1:0] half;
    logic [hci_pkg::IDX_W-1:0] acc;
    logic [1:0]                turn;
    logic [1:0]                flip;
    logic [1:0]                quad;
    logic [1:0]                digit;
    int                        levels;
    px     = hci_pkg::IDX_W'(x);
    py     = hci_pkg::IDX_W'(y);
    acc    = '0;
    turn   = 2'd0;
    flip   = 2'd0;
    levels = (int'(ord) > MAX_ORDER) ? MAX_ORDER : int'(ord);
    for (int lvl = levels; lvl > 0; lvl--) begin
      half = hci_pkg::IDX_W'(1) << (lvl - 1);
      if (px >= half) begin
        quad = (py >= half) ? 2'd2 : 2'd1;
      end else begin
        quad = (py >= half) ? 2'd3 : 2'd0;
      end
      digit = quad + turn;
      acc   = {acc[hci_pkg::IDX_W-3:0], digit ^ flip};
      if (digit == 2'd0 || digit == 2'd3) begin
        flip = flip ^ 2'd3;
      end
      case (digit)
        2'd0: turn = turn + 2'd3;
        2'd3: turn = turn + 2'd1;
        default: turn = turn;
      endcase
      px = px & ~half;
      py = py & ~half;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      order_shadow = hci_pkg::ORDER_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_index_q.size() == 0) begin
          $error("curve_index output word with no expected value: actual %0d",
                 out_curve_index);
          fail_count++;
        end else begin
          if (out_curve_index !== expected_index_q[0]) begin
            $error("curve_index mismatch: expected %0d, actual %0d",
                   expected_index_q[0], out_curve_index);
            fail_count++;
          end
          void'(expected_index_q.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        expected_index_q.push_back(hilbert_distance(in_x_coord, in_y_coord, order_shadow));
      end
      if (cfg_wr_en) begin
        order_shadow = cfg_wr_data;
      end
    end
    words_waiting = expected_index_q.size();
  end

endmodule

// ===== tb/hilbert_curve_index_top_tb.sv =====
// Testbench for the Hilbert index block. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts and compares.
module hilbert_curve_index_top_tb;

  localparam int MAX_ORDER = 16;
  // Pipeline depth from the block's description plus some margin.
  localparam int DRAIN_CYCLES = (MAX_ORDER + 3) / 4 + 1 + 6;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 80;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [hci_pkg::ORD_W-1:0]   cfg_wr_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [hci_pkg::COORD_W-1:0] in_x_coord;
  logic [hci_pkg::COORD_W-1:0] in_y_coord;
  logic                        out_valid;
  logic                        out_ready;
  logic [hci_pkg::IDX_W-1:0]   out_curve_index;

  int fail_count;
  int words_waiting;

  // When set, neither side idles, so the block sees back-to-back words.
  bit calm;

  hilbert_curve_index_top #(
    .MAX_ORDER(MAX_ORDER)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_curve_index(out_curve_index)
  );

  hilbert_curve_index_checker #(
    .MAX_ORDER(MAX_ORDER)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_curve_index(out_curve_index),
    .fail_count     (fail_count),
    .words_waiting  (words_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung handshake ends the run here. The slowest legal run is well under
  // a tenth of this.
  initial begin
    #2000000;
    $display("hilbert_curve_index_top_tb failed");
    $finish;
  end

  // Idle cycles before the next word on either side.
  function automatic int draw_gap();
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Offers one point and returns at the falling edge after it was taken.
  // With a zero gap the valid stays high and only the payload moves on, so
  // valid is never dropped and raised in the same step.
  task automatic send_point(input logic [hci_pkg::COORD_W-1:0] x,
                            input logic [hci_pkg::COORD_W-1:0] y);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds off the sender until every expected word has come out, then lets
  // the pipeline drain a little longer.
  task automatic settle();
    in_valid <= 1'b0;
    while (words_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The order register is written only with the block empty.
  task automatic set_order(input logic [hci_pkg::ORD_W-1:0] ord);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ord;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // A random phase at one order. Most points lie inside the curve's square;
  // the rest carry bits above the top level or sit at the corners.
  task automatic run_random(input logic [hci_pkg::ORD_W-1:0] ord, input int count);
    logic [hci_pkg::COORD_W-1:0] mask;
    logic [hci_pkg::COORD_W-1:0] x;
    logic [hci_pkg::COORD_W-1:0] y;
    int                          lim;
    int                          kind;
    set_order(ord);
    lim  = (int'(ord) > MAX_ORDER) ? MAX_ORDER : int'(ord);
    mask = hci_pkg::COORD_W'((32'h1 << lim) - 1);
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        calm = !calm;
      end
      kind = $urandom_range(0, 9);
      x    = hci_pkg::COORD_W'($urandom);
      y    = hci_pkg::COORD_W'($urandom);
      if (kind < 7) begin
        x = x & mask;
        y = y & mask;
      end else if (kind == 9) begin
        x = $urandom_range(0, 1) ? '1 : '0;
        y = $urandom_range(0, 1) ? mask : '0;
      end
      send_point(x, y);
    end
  endtask

  initial begin
    logic [hci_pkg::ORD_W-1:0] ord;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_x_coord  = '0;
    in_y_coord  = '0;
    calm        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The reset order of 16 is used first, before any write.
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);

    // Directed part: corners and alternating patterns at the full order.
    set_order(5'd16);
    send_point(16'hFFFF, 16'h0000);
    send_point(16'h0000, 16'hFFFF);
    send_point(16'hAAAA, 16'h5555);
    send_point(16'h5555, 16'hAAAA);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'h0001, 16'h0002);

    // Order zero always gives index zero.
    set_order(5'd0);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'h1234, 16'h0000);

    // Orders above the maximum saturate to it.
    set_order(5'd31);
    send_point(16'hFFFF, 16'h0000);
    send_point(16'hAAAA, 16'h5555);
    set_order(5'd17);
    send_point(16'h8001, 16'h4002);

    // Low orders with coordinate bits above the top level, which force the
    // upper half at every level below.
    set_order(5'd3);
    send_point(16'h0007, 16'h0000);
    send_point(16'h0008, 16'h0001);
    send_point(16'h0003, 16'h8000);
    send_point(16'hFFF8, 16'hFFF8);
    set_order(5'd1);
    send_point(16'h0000, 16'h0001);
    send_point(16'h0001, 16'h0001);
    send_point(16'h0002, 16'h0000);
    send_point(16'h0001, 16'h0000);

    // Random phases, starting with the extremes of the order.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: ord = 5'd16;
        1: ord = 5'd1;
        2: ord = 5'd0;
        3: ord = 5'd31;
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            ord = hci_pkg::ORD_W'($urandom_range(1, 16));
          end else begin
            ord = hci_pkg::ORD_W'($urandom_range(0, 31));
          end
        end
      endcase
      run_random(ord, PHASE_ITEMS);
    end

    // Wait for everything outstanding, then let the pipeline drain further so
    // that a stray extra word would still be caught by the checker.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("hilbert_curve_index_top_tb passed");
    end else begin
      $display("hilbert_curve_index_top_tb failed");
    end
    $finish;
  end

  // Receiver: stalls a random number of cycles before each word, keeping
  // ready high through back-to-back words when the gap is zero.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

endmodule
